@@ hdl/ttcb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types and constants of the time-to-collision brake block.
// ----------------------------------------------------------------------------
package ttcb_pkg;

    // one beam of a lidar scan
    typedef struct packed {
        logic [15:0]        range_mm;
        logic               range_bad;
        logic signed [15:0] speed_mm_s;
        logic               last_beam;
    } beam_t;

    // one scan verdict
    typedef struct packed {
        logic        brake;
        logic [11:0] hit_beam;
    } result_t;

    localparam int DEF_MAX_BEAMS   = 4096;
    localparam int DEF_COS_ENTRIES = 1024;

    // configuration register indexes
    localparam logic [2:0] REG_START_ANGLE  = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd1;
    localparam logic [2:0] REG_MIN_RANGE    = 3'd2;
    localparam logic [2:0] REG_MAX_RANGE    = 3'd3;
    localparam logic [2:0] REG_TTC_LIMIT    = 3'd4;

    localparam logic [15:0] RST_START_ANGLE = 16'hA000;
    localparam logic [15:0] RST_ANGLE_STEP  = 16'd45;
    localparam logic [15:0] RST_MIN_RANGE   = 16'd20;
    localparam logic [15:0] RST_MAX_RANGE   = 16'd30000;
    localparam logic [15:0] RST_TTC_LIMIT   = 16'd1000;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;

    localparam int COS_W    = 16;
    localparam int IDX_W    = 12;
    localparam int BEAM_W   = 12;

endpackage : ttcb_pkg
`default_nettype wire

@@ hdl/time_to_collision_brake.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// time_to_collision_brake
// Lidar scan time-to-collision check: one beam a word, one verdict per scan.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                        payload
//  beam      in         beam_valid / beam_stall          beam (beam_t)
//  result    out        result_valid / result_stall      result (result_t)
//  config    in         psel penable pwrite paddr pwdata prdata pready
//
//  a beam goes through the accept step (cosine rom read, range * 1000),
//  then speed * cos, limit * closing speed and the compare; the products
//  share one 18x32 signed multiplier, stepped by a four-state sequencer
//  reset is immediate, no clearing pass; the final beam of a scan waits in the
//  compare step while an earlier verdict is still stalled at the output
// ----------------------------------------------------------------------------
module time_to_collision_brake #(
    parameter int MAX_BEAMS   = ttcb_pkg::DEF_MAX_BEAMS,
    parameter int COS_ENTRIES = ttcb_pkg::DEF_COS_ENTRIES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             beam_valid,
    output logic                  beam_stall,
    input  wire ttcb_pkg::beam_t  beam,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output ttcb_pkg::result_t     result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ttcb_pkg::*;

    localparam int BEAM_TOP = (MAX_BEAMS - 1 > 4095) ? 4095 : MAX_BEAMS - 1;
    localparam int ROM_AW   = $clog2(COS_ENTRIES + 1);
    localparam int POS_PW   = 15 + ROM_AW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_CMP  = 2'd3;

    typedef logic [COS_W-1:0] rom_t [0:COS_ENTRIES];

    function automatic logic [COS_W-1:0] cos_entry(int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        x    = (64'(k) * HALF_PI_Q30) / 64'(COS_ENTRIES);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32768)
        begin
            q = 64'd32768;
        end
        return q[COS_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= COS_ENTRIES; k++)
        begin
            r[k] = cos_entry(k);
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    // configuration
    logic [15:0] start_angle_reg;
    logic [15:0] angle_step_reg;
    logic [15:0] min_range_reg;
    logic [15:0] max_range_reg;
    logic [15:0] ttc_limit_reg;

    // scan state
    logic [BEAM_W-1:0] beam_count_reg;
    logic [15:0]       beam_angle_reg;
    logic              hit_seen_reg;
    logic [BEAM_W-1:0] hit_index_reg;

    // item in flight
    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic               beam_ok_reg;
    logic               last_reg;
    logic signed [15:0] speed_reg;
    logic               neg_reg;
    logic [COS_W-1:0]   cos_reg;
    logic [25:0]        lhs_reg;
    logic [30:0]        closing_reg;
    logic [45:0]        rhs_reg;

    logic              result_valid_reg;
    result_t           result_reg;

    logic               accept;
    logic               cfg_write;
    logic [15:0]        cur_angle;
    logic [1:0]         quad;
    logic [14:0]        pos;
    logic [POS_PW-1:0]  pos_prod;
    logic [ROM_AW-1:0]  rom_idx;
    logic signed [16:0] cos_s;
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [49:0] mul_p;
    logic [30:0]        closing_next;
    logic [45:0]        lhs_ext;
    logic               hit;
    logic               seen_now;
    logic [BEAM_W-1:0]  idx_now;
    logic               cmp_hold;

    assign pready       = 1'b1;
    assign beam_stall   = (state_reg != ST_IDLE);
    assign accept       = beam_valid && !beam_stall;
    assign cfg_write    = psel && penable && pwrite;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // angle of this beam, rom address from the quadrant folding
    assign cur_angle = (beam_count_reg == '0) ? start_angle_reg : beam_angle_reg;
    assign quad      = cur_angle[15:14];
    assign pos       = quad[0] ? (15'd16384 - {1'b0, cur_angle[13:0]})
                               : {1'b0, cur_angle[13:0]};
    assign pos_prod  = POS_PW'(pos) * POS_PW'(COS_ENTRIES);
    assign rom_idx   = pos_prod[14 +: ROM_AW];

    assign cos_s = neg_reg ? -$signed({1'b0, cos_reg}) : $signed({1'b0, cos_reg});

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = $signed({2'b00, beam.range_mm});
                mul_b = 32'sd1000;
            end
            ST_MUL1:
            begin
                mul_a = 18'(speed_reg);
                mul_b = 32'(cos_s);
            end
            ST_MUL2:
            begin
                mul_a = $signed({2'b00, ttc_limit_reg});
                mul_b = $signed({1'b0, closing_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    // closing speed floor of 1 mm/s
    assign closing_next = (mul_p < 50'sd32768) ? 31'd32768 : mul_p[30:0];

    assign lhs_ext  = {5'd0, lhs_reg, 15'd0};
    assign hit      = beam_ok_reg && (lhs_ext < rhs_reg);
    assign seen_now = hit_seen_reg || hit;
    assign idx_now  = (hit && !hit_seen_reg) ? beam_count_reg : hit_index_reg;
    assign cmp_hold = last_reg && result_valid_reg && result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_CMP;
            ST_CMP:
            begin
                if (!cmp_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beam_ok_reg <= !beam.range_bad && (beam.range_mm >= min_range_reg)
                           && (beam.range_mm <= max_range_reg);
            last_reg    <= beam.last_beam;
            speed_reg   <= beam.speed_mm_s;
            neg_reg     <= quad[1] ^ quad[0];
            cos_reg     <= COS_ROM[rom_idx];
            lhs_reg     <= mul_p[25:0];
        end
        if (state_reg == ST_MUL1)
        begin
            closing_reg <= closing_next;
        end
        if (state_reg == ST_MUL2)
        begin
            rhs_reg <= mul_p[45:0];
        end
    end

    // scan state and verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_count_reg   <= '0;
            beam_angle_reg   <= '0;
            hit_seen_reg     <= 1'b0;
            hit_index_reg    <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // a final beam in the compare step reloads the verdict instead
            if (result_valid_reg && !result_stall
                && !(state_reg == ST_CMP && last_reg))
            begin
                result_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CMP && !cmp_hold)
            begin
                if (last_reg)
                begin
                    result_valid_reg    <= 1'b1;
                    result_reg.brake    <= seen_now;
                    result_reg.hit_beam <= seen_now ? idx_now : '0;
                    beam_count_reg      <= '0;
                    beam_angle_reg      <= '0;
                    hit_seen_reg        <= 1'b0;
                    hit_index_reg       <= '0;
                end
                else
                begin
                    hit_seen_reg  <= seen_now;
                    hit_index_reg <= idx_now;
                    if (beam_count_reg < BEAM_W'(BEAM_TOP))
                    begin
                        beam_count_reg <= beam_count_reg + 1'b1;
                        beam_angle_reg <= cur_angle + angle_step_reg;
                    end
                    else
                    begin
                        beam_angle_reg <= cur_angle;
                    end
                end
            end
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= RST_START_ANGLE;
            angle_step_reg  <= RST_ANGLE_STEP;
            min_range_reg   <= RST_MIN_RANGE;
            max_range_reg   <= RST_MAX_RANGE;
            ttc_limit_reg   <= RST_TTC_LIMIT;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_START_ANGLE: start_angle_reg <= pwdata[15:0];
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata[15:0];
                REG_MIN_RANGE:   min_range_reg   <= pwdata[15:0];
                REG_MAX_RANGE:   max_range_reg   <= pwdata[15:0];
                REG_TTC_LIMIT:   ttc_limit_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_START_ANGLE: prdata = {16'd0, start_angle_reg};
            REG_ANGLE_STEP:  prdata = {16'd0, angle_step_reg};
            REG_MIN_RANGE:   prdata = {16'd0, min_range_reg};
            REG_MAX_RANGE:   prdata = {16'd0, max_range_reg};
            REG_TTC_LIMIT:   prdata = {16'd0, ttc_limit_reg};
            default:         prdata = '0;
        endcase
    end

endmodule : time_to_collision_brake
`default_nettype wire
